@@ rtl/core/sshb_pkg.sv @@
// shared types, constants and per-byte hash helpers for the string hash bucket block
// no dependencies
package sshb_pkg;

	localparam int HASH_W  = 32;
	localparam int CFG_IDX_W = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_ALG     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = 2'd1;

	// algorithm codes, 5 to 7 behave as fnv-1a
	localparam logic [2:0] ALG_MULT  = 3'd0;
	localparam logic [2:0] ALG_FNV   = 3'd1;
	localparam logic [2:0] ALG_DJB   = 3'd2;
	localparam logic [2:0] ALG_SDBM  = 3'd3;
	localparam logic [2:0] ALG_JOAAT = 3'd4;

	localparam logic [HASH_W-1:0] FNV_BASIS   = 32'h811c_9dc5;
	localparam logic [HASH_W-1:0] FNV_MULT    = 32'h0100_0193;
	localparam logic [HASH_W-1:0] DJB_SEED    = 32'd5381;
	localparam logic [HASH_W-1:0] DJB_MULT    = 32'd33;
	localparam logic [HASH_W-1:0] SDBM_MULT   = 32'd65599;   // 2^16 + 2^6 - 1
	localparam logic [HASH_W-1:0] JOAAT_MULT  = 32'd1025;    // h += h << 10
	localparam logic [HASH_W-1:0] JOAAT_MIX1  = 32'd9;       // h += h << 3
	localparam logic [HASH_W-1:0] JOAAT_MIX2  = 32'd32769;   // h += h << 15
	localparam logic [63:0]       GOLDEN_FRAC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [HASH_W-1:0] DEFAULT_BUCKETS = 32'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_POST,
		ST_DIV,
		ST_DONE
	} state_t;

	// what the current pass of the shift-add unit computes
	typedef enum logic [2:0] {
		JOB_BYTE,
		JOB_MIX1,
		JOB_MIX2,
		JOB_GOLD1,
		JOB_GOLD2
	} job_t;

	function automatic logic [HASH_W-1:0] seed_of(input logic [2:0] alg);
		logic [HASH_W-1:0] s;
		case (alg)
			ALG_MULT, ALG_SDBM, ALG_JOAAT: s = '0;
			ALG_DJB:                        s = DJB_SEED;
			default:                        s = FNV_BASIS;
		endcase
		return s;
	endfunction

	// constant multiplier of the per-byte step
	function automatic logic [HASH_W-1:0] byte_mult(input logic [2:0] alg);
		logic [HASH_W-1:0] k;
		case (alg)
			ALG_DJB:   k = DJB_MULT;
			ALG_SDBM:  k = SDBM_MULT;
			ALG_JOAAT: k = JOAAT_MULT;
			default:   k = FNV_MULT;
		endcase
		return k;
	endfunction

	// operand fed to the multiplier
	function automatic logic [HASH_W-1:0] byte_pre(input logic [2:0] alg,
			input logic [HASH_W-1:0] h, input logic [HASH_W-1:0] sx);
		logic [HASH_W-1:0] r;
		case (alg)
			ALG_DJB, ALG_SDBM: r = h;
			ALG_JOAAT:         r = h + sx;
			default:           r = h ^ sx;
		endcase
		return r;
	endfunction

	// fix-up after the product
	function automatic logic [HASH_W-1:0] byte_post(input logic [2:0] alg,
			input logic [HASH_W-1:0] p, input logic [HASH_W-1:0] sx);
		logic [HASH_W-1:0] r;
		case (alg)
			ALG_DJB:   r = p ^ sx;
			ALG_SDBM:  r = p + sx;
			ALG_JOAAT: r = p ^ (p >> 6);
			default:   r = p;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/selectable_string_hash_bucket_top.sv @@
// string hash with selectable algorithm, reduced to a bucket index
// depends on sshb_pkg (types, constants, per-byte hash helpers)
//
// usage
//   input channel: key_byte / last_byte with in_valid, in_stall. one request is one
//   key byte; the byte flagged last_byte closes the key and yields one bucket_index
//   request on the output channel (out_valid, out_stall). other bytes yield nothing.
//   config channel: cfg_valid / cfg_ready, cfg_index 0 = algorithm, 1 = bucket count,
//   other indexes are dropped. writing the algorithm restarts the key in progress.
//   timing: all multiplies and divisions go through one shift-add unit with a 65-bit adder,
//   one multiplier bit or one remainder bit per cycle. the multiplicative hash only
//   sums its bytes, and its last byte runs the golden-ratio and bucket-scaling multiplies;
//   other hashes run a multiply pass per byte and a division for the last byte (none if
//   bucket count is zero), and one-at-a-time adds the multiply passes of its final mix
//   in_stall is high while the unit works. the result sits in an output register,
//   so a new key is accepted while it waits; if the receiver still stalls when the
//   next result is ready, the block holds in its done state.
//   reset: algorithm 0, bucket count 11, hash and byte sum cleared, no result pending
module selectable_string_hash_bucket_top
	import sshb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// key bytes
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           key_byte,
	input  logic                 last_byte,
	// bucket index
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [HASH_W-1:0]    bucket_index,
	// config writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HASH_W-1:0]    cfg_data
);

	// sequencer
	state_t st_q, st_d;
	job_t   job_q, job_d;
	logic [4:0] cnt_q, cnt_d;

	// shift-add unit: product = lo (multiplier) * mcand, high part in hi
	// during division hi holds the remainder and lo shifts out the dividend
	logic [63:0]       hi_q, hi_d;
	logic [HASH_W-1:0] lo_q, lo_d;
	logic [63:0]       mcand_q, mcand_d;
	logic [64:0]       add_a, add_b, add_sum;
	logic              add_cin;

	// key state and config
	logic [HASH_W-1:0] hash_q, hash_d;
	logic [HASH_W-1:0] sum_q, sum_d;
	logic [2:0]        alg_q, alg_d;
	logic [HASH_W-1:0] buckets_q, buckets_d;
	logic [HASH_W-1:0] sx_q, sx_d;
	logic              last_q, last_d;

	// output register
	logic [HASH_W-1:0] res_q, res_d;
	logic              out_valid_q, out_valid_d;
	logic              out_free;

	// per-byte values
	logic [HASH_W-1:0] sx_in;
	logic [HASH_W-1:0] byte_hash;
	logic [HASH_W-1:0] red_val;
	logic              do_reduce;

	assign sx_in     = {{24{key_byte[7]}}, key_byte};
	assign byte_hash = byte_post(alg_q, lo_q, sx_q);
	assign add_sum   = add_a + add_b + {64'b0, add_cin};
	assign out_free  = !out_valid_q || !out_stall;

	assign in_stall     = (st_q != ST_IDLE);
	assign cfg_ready    = (st_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign bucket_index = res_q;

	always_comb begin
		st_d        = st_q;
		job_d       = job_q;
		cnt_d       = cnt_q;
		hi_d        = hi_q;
		lo_d        = lo_q;
		mcand_d     = mcand_q;
		hash_d      = hash_q;
		sum_d       = sum_q;
		alg_d       = alg_q;
		buckets_d   = buckets_q;
		sx_d        = sx_q;
		last_d      = last_q;
		res_d       = res_q;
		out_valid_d = out_valid_q;
		add_a       = '0;
		add_b       = '0;
		add_cin     = 1'b0;
		red_val     = lo_q;
		do_reduce   = 1'b0;

		// receiver took the pending result
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					sx_d   = sx_in;
					last_d = last_byte;
					sum_d  = last_byte ? '0 : sum_q + sx_in;
					if (alg_q == ALG_MULT) begin
						// only the byte sum matters until the key ends
						if (last_byte) begin
							hi_d    = '0;
							lo_d    = sum_q + sx_in;
							mcand_d = GOLDEN_FRAC;
							cnt_d   = '0;
							job_d   = JOB_GOLD1;
							st_d    = ST_MUL;
						end
					end else begin
						hi_d    = '0;
						lo_d    = byte_mult(alg_q);
						mcand_d = {32'b0, byte_pre(alg_q, hash_q, sx_in)};
						cnt_d   = '0;
						job_d   = JOB_BYTE;
						st_d    = ST_MUL;
					end
				end
			end

			ST_MUL: begin
				// one multiplier bit per cycle, product shifts down into lo
				add_a = {1'b0, hi_q};
				add_b = lo_q[0] ? {1'b0, mcand_q} : '0;
				hi_d  = add_sum[64:1];
				lo_d  = {add_sum[0], lo_q[HASH_W-1:1]};
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					st_d = ST_POST;
				end
			end

			ST_POST: begin
				unique case (job_q)
					JOB_BYTE: begin
						hash_d = last_q ? seed_of(alg_q) : byte_hash;
						if (!last_q) begin
							st_d = ST_IDLE;
						end else if (alg_q == ALG_JOAAT) begin
							hi_d    = '0;
							lo_d    = JOAAT_MIX1;
							mcand_d = {32'b0, byte_hash};
							cnt_d   = '0;
							job_d   = JOB_MIX1;
							st_d    = ST_MUL;
						end else begin
							red_val   = byte_hash;
							do_reduce = 1'b1;
						end
					end
					JOB_MIX1: begin
						hi_d    = '0;
						lo_d    = JOAAT_MIX2;
						mcand_d = {32'b0, lo_q ^ (lo_q >> 11)};
						cnt_d   = '0;
						job_d   = JOB_MIX2;
						st_d    = ST_MUL;
					end
					JOB_MIX2: begin
						red_val   = lo_q;
						do_reduce = 1'b1;
					end
					JOB_GOLD1: begin
						// scale the 0.64 fraction by the bucket count
						hi_d    = '0;
						lo_d    = buckets_q;
						mcand_d = {hi_q[31:0], lo_q};
						cnt_d   = '0;
						job_d   = JOB_GOLD2;
						st_d    = ST_MUL;
					end
					JOB_GOLD2: begin
						hi_d = {32'b0, hi_q[63:32]};
						st_d = ST_DONE;
					end
					default: begin
						st_d = ST_IDLE;
					end
				endcase

				// zero bucket count passes the hash through
				if (do_reduce) begin
					if (buckets_q == '0) begin
						hi_d = {32'b0, red_val};
						st_d = ST_DONE;
					end else begin
						hi_d  = '0;
						lo_d  = red_val;
						cnt_d = '0;
						st_d  = ST_DIV;
					end
				end
			end

			ST_DIV: begin
				// restoring step: shift in next dividend bit, subtract if it fits
				add_a   = {32'b0, hi_q[31:0], lo_q[HASH_W-1]};
				add_b   = ~{33'b0, buckets_q};
				add_cin = 1'b1;
				if (add_sum[64]) begin
					hi_d = {31'b0, hi_q[31:0], lo_q[HASH_W-1]};
				end else begin
					hi_d = {32'b0, add_sum[31:0]};
				end
				lo_d  = {lo_q[HASH_W-2:0], 1'b0};
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					st_d = ST_DONE;
				end
			end

			ST_DONE: begin
				if (out_free) begin
					res_d       = hi_q[31:0];
					out_valid_d = 1'b1;
					st_d        = ST_IDLE;
				end
			end

			default: begin
				st_d = ST_IDLE;
			end
		endcase

		// config writes, only taken while idle
		if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ALG: begin
					alg_d  = cfg_data[2:0];
					hash_d = seed_of(cfg_data[2:0]);
					sum_d  = '0;
				end
				CFG_BUCKETS: begin
					buckets_d = cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			job_q       <= JOB_BYTE;
			hash_q      <= seed_of(ALG_MULT);
			sum_q       <= '0;
			alg_q       <= ALG_MULT;
			buckets_q   <= DEFAULT_BUCKETS;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			job_q       <= job_d;
			hash_q      <= hash_d;
			sum_q       <= sum_d;
			alg_q       <= alg_d;
			buckets_q   <= buckets_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		cnt_q   <= cnt_d;
		hi_q    <= hi_d;
		lo_q    <= lo_d;
		mcand_q <= mcand_d;
		sx_q    <= sx_d;
		res_q   <= res_d;
	end

`ifndef NO_ASSERTIONS
	// a hashed byte always starts a multiply pass
	a_byte_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && alg_q != ALG_MULT) |=> (st_q == ST_MUL))
		else $error("accepted byte did not start the multiplier");

	// remainder stays below the divisor through the division
	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (hi_q[31:0] < buckets_q))
		else $error("remainder reached bucket count");

	// a pass is exactly 32 steps
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL && cnt_q == 5'd31) |=> (st_q == ST_POST))
		else $error("multiply pass did not end after 32 steps");

	// finished result lands in the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && out_free) |=> (out_valid_q && st_q == ST_IDLE))
		else $error("result not loaded from done state");

	// never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(res_q))
		else $error("pending result overwritten");
`endif

endmodule

@@ tb/sv/selectable_string_hash_bucket_top_tb.sv @@
// self-checking bench for selectable_string_hash_bucket_top: keys streamed byte by byte,
// bucket indexes checked against an in-bench predictor under every algorithm code and selected bucket counts
// depends on sshb_pkg and the rtl top level only
module selectable_string_hash_bucket_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sshb_pkg::*;

	// config indexes the block has no register for
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam logic [2:0] ALG_FNV_ALT5 = 3'd5;
	localparam logic [2:0] ALG_FNV_ALT6 = 3'd6;
	localparam logic [2:0] ALG_FNV_ALT7 = 3'd7;

	// settle time, rounded up well past what a one-at-a-time last byte needs
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 5000;
	localparam int RESET_CYCLES  = 11;
	localparam int PHASES        = 16;
	localparam int PHASE_BYTES   = 120;
	localparam int HOLD_CYCLES   = 400;

	// running hash predictor plus the queue of bucket indexes still owed by the block
	class bucket_scoreboard;
		logic [2:0]        alg;
		logic [HASH_W-1:0] buckets;
		logic [HASH_W-1:0] hash;
		logic [HASH_W-1:0] sum;
		logic [HASH_W-1:0] expected_buckets[$];
		int                mismatches;

		function new();
			alg = ALG_MULT;
			buckets = DEFAULT_BUCKETS;
			mismatches = 0;
			restart_key();
		endfunction

		function void restart_key();
			case (alg)
				ALG_MULT, ALG_SDBM, ALG_JOAAT: hash = '0;
				ALG_DJB:                        hash = DJB_SEED;
				default:                        hash = FNV_BASIS;
			endcase
			sum = '0;
		endfunction

		function void apply_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [HASH_W-1:0] data);
			if (idx == CFG_ALG) begin
				alg = data[2:0];
				restart_key();
			end else if (idx == CFG_BUCKETS) begin
				buckets = data;
			end
		endfunction

		function void absorb_key_byte(input logic [7:0] b, input logic lst);
			logic [HASH_W-1:0] sx;
			logic [63:0]       frac;
			logic [95:0]       prod;
			logic [HASH_W-1:0] h;
			logic [HASH_W-1:0] idx;
			sx = {{24{b[7]}}, b};
			h = hash;
			sum = sum + sx;
			case (alg)
				ALG_MULT: ;
				ALG_DJB: h = (h * DJB_MULT) ^ sx;
				ALG_SDBM: h = sx + (h << 6) + (h << 16) - h;
				ALG_JOAAT: begin
					h = h + sx;
					h = h + (h << 10);
					h = h ^ (h >> 6);
				end
				default: begin
					h = h ^ sx;
					h = h * FNV_MULT;
				end
			endcase
			hash = h;
			if (lst) begin
				if (alg == ALG_MULT) begin
					frac = {32'd0, sum} * GOLDEN_FRAC;
					prod = {64'd0, buckets} * {32'd0, frac};
					idx = prod[95:64];
				end else begin
					if (alg == ALG_JOAAT) begin
						h = h + (h << 3);
						h = h ^ (h >> 11);
						h = h + (h << 15);
					end
					idx = (buckets == '0) ? h : h % buckets;
				end
				expected_buckets.push_back(idx);
				restart_key();
			end
		endfunction

		function int pending();
			return expected_buckets.size();
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t ERROR %s", $realtime, msg);
		endtask

		task check_bucket(input logic [HASH_W-1:0] got);
			logic [HASH_W-1:0] want;
			if (expected_buckets.size() == 0) begin
				report($sformatf("unexpected bucket_index %h", got));
			end else begin
				want = expected_buckets.pop_front();
				if (got !== want)
					report($sformatf("bucket_index got %h want %h", got, want));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           key_byte;
	logic                 last_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [HASH_W-1:0]    bucket_index;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HASH_W-1:0]    cfg_data;

	bucket_scoreboard sb = new();

	// idle percentages per side, and the receiver hold-off counter
	int tx_idle_pct = 17;
	int rx_idle_pct = 17;
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	selectable_string_hash_bucket_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_byte     (key_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bucket_index (bucket_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, or a counted hold-off when the main flow asks for one
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_stall = 1'b1;
				rx_hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// every accepted bucket_index request goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_bucket(bucket_index);
	end

	// watchdog: too long without any handshake on any channel means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ERROR no handshake for %0d cycles", $realtime, quiet_cycles);
			$display("selectable_string_hash_bucket_top test failed");
			$finish;
		end
	end

	// one key byte request, with random idle cycles ahead of it; called and left at a falling edge
	task automatic send_key_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < tx_idle_pct)
			@(negedge clk);
		key_byte = b;
		last_byte = lst;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.absorb_key_byte(b, lst);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// all results in, then enough cycles for a byte that owes no result to finish
	task automatic wait_for_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
		wait_for_idle();
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// algorithm write with junk in the unused upper bits
	task automatic set_algorithm(input logic [2:0] alg);
		write_reg(CFG_ALG, ($urandom() & 32'hFFFF_FFF8) | {29'd0, alg});
	endtask

	// byte values lean toward the sign boundary and the ends of the range
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(11))
			0: b = 8'h00;
			1: b = 8'h7f;
			2: b = 8'h80;
			3: b = 8'hff;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	function automatic logic [HASH_W-1:0] pick_buckets(input int sel);
		logic [HASH_W-1:0] n;
		case (sel % 8)
			0: n = 32'd1;
			1: n = 32'd0;
			2: n = 32'hFFFF_FFFF;
			3: n = $urandom_range(2, 16);
			4: n = $urandom();
			5: n = 32'h8000_0000;
			6: n = $urandom_range(17, 5000);
			default: n = DEFAULT_BUCKETS;
		endcase
		return n;
	endfunction

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_byte = '0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ALG;
		cfg_data = '0;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: multiplicative hash, 11 buckets, bytes at the sign edges
		send_key_byte(8'hff, 1'b0);
		send_key_byte(8'h80, 1'b0);
		send_key_byte(8'h7f, 1'b0);
		send_key_byte(8'h00, 1'b1);

		// zero bucket count: fnv-1a passes the full hash, multiplicative gives zero
		set_algorithm(ALG_FNV);
		write_reg(CFG_BUCKETS, 32'd0);
		send_key_byte(8'hff, 1'b1);
		set_algorithm(ALG_MULT);
		send_key_byte(8'h80, 1'b1);

		// remaining algorithms, two of them at the bucket count extremes
		set_algorithm(ALG_DJB);
		write_reg(CFG_BUCKETS, 32'hFFFF_FFFF);
		send_key_byte(8'h41, 1'b0);
		send_key_byte(8'hc3, 1'b1);
		set_algorithm(ALG_SDBM);
		write_reg(CFG_BUCKETS, 32'd1);
		send_key_byte(8'h7f, 1'b0);
		send_key_byte(8'hff, 1'b1);
		set_algorithm(ALG_JOAAT);
		write_reg(CFG_BUCKETS, 32'd1000);
		send_key_byte(8'h01, 1'b0);
		send_key_byte(8'h80, 1'b0);
		send_key_byte(8'hfe, 1'b1);

		// codes above one-at-a-time fall back to fnv-1a
		set_algorithm(ALG_FNV_ALT5);
		send_key_byte(8'h61, 1'b1);
		set_algorithm(ALG_FNV_ALT6);
		send_key_byte(8'h80, 1'b1);
		set_algorithm(ALG_FNV_ALT7);
		send_key_byte(8'hff, 1'b1);

		// bucket count changed in mid-key keeps the running hash
		set_algorithm(ALG_JOAAT);
		send_key_byte(8'h12, 1'b0);
		send_key_byte(8'h34, 1'b0);
		write_reg(CFG_BUCKETS, 32'd97);
		send_key_byte(8'h56, 1'b1);

		// algorithm changed in mid-key drops the partial key
		send_key_byte(8'h9a, 1'b0);
		set_algorithm(ALG_DJB);
		send_key_byte(8'h77, 1'b1);

		// writes to indexes with no register change nothing
		write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_B, 32'h0000_0005);
		send_key_byte(8'h55, 1'b1);

		// random phases, each with its own algorithm and bucket count
		for (int p = 0; p < PHASES; p++) begin
			set_algorithm(p[2:0]);
			write_reg(CFG_BUCKETS, pick_buckets(p + 3 * (p / 8)));
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());

			// one phase runs flat out on both sides
			tx_idle_pct = (p == 3 || p == 6) ? 0 : 17;
			rx_idle_pct = (p == 3) ? 0 : 17;
			// receiver holds off while keys keep coming, so the block backs up
			if (p == 6)
				rx_hold_left = HOLD_CYCLES;

			sent = 0;
			while (sent < PHASE_BYTES) begin
				// mostly short keys, now and then a long one
				len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					send_key_byte(pick_byte(), i == len - 1);
				sent += len;
				// sender stops until the output side has drained
				if (p == 9 && sent >= PHASE_BYTES / 2 && sent - len < PHASE_BYTES / 2)
					wait_for_idle();
			end

			// leave a partial key open for the next config write to hit
			if ($urandom_range(2) == 0) begin
				len = $urandom_range(1, 2);
				for (int i = 0; i < len; i++)
					send_key_byte(pick_byte(), 1'b0);
			end
		end

		// drain, let any result-free byte finish, then decide
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d bucket indexes never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("selectable_string_hash_bucket_top test passed");
		else
			$display("selectable_string_hash_bucket_top test failed");
		$finish;
	end

endmodule

@@ selectable_string_hash_bucket_top.f @@
rtl/core/sshb_pkg.sv
rtl/core/selectable_string_hash_bucket_top.sv
tb/sv/selectable_string_hash_bucket_top_tb.sv
